// File: sv/fsc_pkg.sv
package fsc_pkg;

   localparam int CACHE_ENTRIES = 256;
   localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
   localparam int WORD_W        = 32;
   localparam int NUM_WORDS     = 6;
   localparam int KEY_W         = 64;
   localparam int FRAME_W       = 31;
   localparam int SLOT_W        = 8;
   localparam int COUNT_W       = 32;

   localparam logic [KEY_W-1:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;

   typedef logic [NUM_WORDS-1:0][WORD_W-1:0] word_vec_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [KEY_W-1:0]   key;
      logic [FRAME_W-1:0] stamp;
   } mem_wr_type;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [SLOT_W+IDX_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
   endfunction

endpackage

// File: sv/frame_stamped_hash_cache.sv
// Flow: an accepted request beat is hashed by the six-step hash unit; the valid entries
// are then scanned (skipped in an empty frame) until a match or the last entry.
// Queries: one at a time; the next request beat can be taken the cycle after the
// response register is loaded.
// Reset: synchronous, active high; no frame seen, counters zero, no entry valid;
// entry memories are not cleared: a fill count marks the valid prefix.
module frame_stamped_hash_cache
   import fsc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [WORD_W-1:0]   req_min_x_bits,
   input  logic [WORD_W-1:0]   req_min_y_bits,
   input  logic [WORD_W-1:0]   req_min_z_bits,
   input  logic [WORD_W-1:0]   req_max_x_bits,
   input  logic [WORD_W-1:0]   req_max_y_bits,
   input  logic [WORD_W-1:0]   req_max_z_bits,
   input  logic [FRAME_W-1:0]  req_frame,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [COUNT_W-1:0]  rsp_hit_count,
   output logic [COUNT_W-1:0]  rsp_miss_count
);

   state_type          state_ff, state_in;
   word_vec_type       words_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [FRAME_W-1:0] last_frame_ff;
   logic               seen_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [COUNT_W-1:0] hits_ff;
   logic [COUNT_W-1:0] misses_ff;
   logic [CNT_W-1:0]   raddr_ff;
   logic               pend_ff;
   logic [IDX_W-1:0]   pend_idx_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [FRAME_W-1:0] min_stamp_ff;
   logic [IDX_W-1:0]   min_idx_ff;
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [COUNT_W-1:0] rsp_hit_count_ff;
   logic [COUNT_W-1:0] rsp_miss_count_ff;

   logic               accept;
   logic               new_frame;
   logic               hash_done;
   logic [KEY_W-1:0]   key;
   logic [KEY_W-1:0]   rd_key;
   logic [FRAME_W-1:0] rd_stamp;
   logic               issue_ok;
   logic               rd_en;
   logic               scan_match;
   logic               scan_last;
   logic               rsp_free;
   logic               finish_go;
   logic               full;
   logic [IDX_W-1:0]   miss_idx;
   logic [IDX_W-1:0]   slot_idx;
   logic [COUNT_W-1:0] hits_in;
   logic [COUNT_W-1:0] misses_in;
   mem_wr_type         mem_wr;

   fsc_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .words (words_ff),
      .done  (hash_done),
      .key   (key)
   );

   fsc_mem u_mem (
      .clock    (clock),
      .mem_wr   (mem_wr),
      .rd_en    (rd_en),
      .rd_addr  (raddr_ff[IDX_W-1:0]),
      .rd_key   (rd_key),
      .rd_stamp (rd_stamp)
   );

   assign issue_ok   = (raddr_ff < fill_ff);
   assign scan_match = pend_ff && (rd_key == key) && (rd_stamp == frame_ff);
   assign scan_last  = pend_ff && ((CNT_W'(pend_idx_ff) + CNT_W'(1)) == fill_ff);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign new_frame  = !seen_ff || (req_frame != last_frame_ff);
   assign full       = (fill_ff == CNT_W'(CACHE_ENTRIES));
   assign miss_idx   = full ? min_idx_ff : fill_ff[IDX_W-1:0];
   assign slot_idx   = hit_ff ? hit_idx_ff : miss_idx;
   assign hits_in    = hit_ff ? sat_inc(hits_ff) : hits_ff;
   assign misses_in  = hit_ff ? misses_ff : sat_inc(misses_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_HASH;
         end
         ST_HASH: begin
            if (hash_done) state_in = (fill_ff == '0) ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_match || scan_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      rd_en     = 1'b0;
      finish_go = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         ST_SCAN: begin
            rd_en = issue_ok;
         end
         ST_FINISH: begin
            finish_go = rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      mem_wr.en    = finish_go && !hit_ff;
      mem_wr.addr  = slot_idx;
      mem_wr.key   = key;
      mem_wr.stamp = frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_frame_ff <= '0;
         seen_ff       <= 1'b0;
         fill_ff       <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         pend_ff       <= 1'b0;
         raddr_ff      <= '0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            hit_ff   <= 1'b0;
            raddr_ff <= '0;
            if (new_frame) begin
               last_frame_ff <= req_frame;
               seen_ff       <= 1'b1;
               fill_ff       <= '0;
               hits_ff       <= '0;
               misses_ff     <= '0;
            end
         end
         if (state_ff == ST_SCAN) begin
            pend_ff <= rd_en;
            if (rd_en) raddr_ff <= raddr_ff + CNT_W'(1);
            if (scan_match) hit_ff <= 1'b1;
         end else begin
            pend_ff <= 1'b0;
         end
         if (finish_go) begin
            hits_ff   <= hits_in;
            misses_ff <= misses_in;
            if (!hit_ff && !full) fill_ff <= fill_ff + CNT_W'(1);
         end
         if (finish_go) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         words_ff <= {req_max_z_bits, req_max_y_bits, req_max_x_bits,
                      req_min_z_bits, req_min_y_bits, req_min_x_bits};
         frame_ff <= req_frame;
      end
      if (rd_en) pend_idx_ff <= raddr_ff[IDX_W-1:0];
      if (state_ff == ST_SCAN && pend_ff) begin
         if (scan_match) hit_idx_ff <= pend_idx_ff;
         if (pend_idx_ff == '0 || rd_stamp < min_stamp_ff) begin
            min_stamp_ff <= rd_stamp;
            min_idx_ff   <= pend_idx_ff;
         end
      end
      if (finish_go) begin
         rsp_hit_ff        <= hit_ff;
         rsp_slot_ff       <= slot_of(slot_idx);
         rsp_hit_count_ff  <= hits_in;
         rsp_miss_count_ff <= misses_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_hit_count  = rsp_hit_count_ff;
   assign rsp_miss_count = rsp_miss_count_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CACHE_ENTRIES))
      else $error("fill count beyond cache depth");

   a_accept_hash: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_HASH)
      else $error("accepted beat did not start hashing");

   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> rsp_hit_count != '0)
      else $error("hit beat with zero hit count");

   a_miss_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> rsp_miss_count != '0)
      else $error("fill beat with zero miss count");

   a_hit_in_prefix: assert property (@(posedge clock) disable iff (reset)
      (finish_go && hit_ff) |-> (CNT_W'(hit_idx_ff) < fill_ff))
      else $error("hit outside valid entries");
`endif

endmodule

// File: sv/fsc_hash.sv
module fsc_hash
   import fsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  word_vec_type     words,
   output logic             done,
   output logic [KEY_W-1:0] key
);

   logic             busy_ff, busy_in;
   logic [2:0]       step_ff, step_in;
   logic             done_ff, done_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] mixed;
   logic [KEY_W-1:0] product;
   logic             last_step;

   assign last_step = (step_ff == 3'(NUM_WORDS - 1));

   // prime is 2^40 + 0x1B3, so the product is a handful of shifted adds
   always_comb begin
      mixed   = key_ff ^ {{(KEY_W-WORD_W){1'b0}}, words[step_ff]};
      product = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
              + (mixed << 4) + (mixed << 1) + mixed;
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      key_in  = key_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         key_in  = HASH_BASIS;
      end else if (busy_ff) begin
         key_in  = product;
         step_in = step_ff + 3'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
      key_ff <= key_in;
   end

   assign done = done_ff;
   assign key  = key_ff;

endmodule

// File: sv/fsc_mem.sv
module fsc_mem
   import fsc_pkg::*;
(
   input  logic               clock,
   input  mem_wr_type         mem_wr,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [KEY_W-1:0]   rd_key,
   output logic [FRAME_W-1:0] rd_stamp
);

   logic [KEY_W-1:0]   key_mem   [CACHE_ENTRIES];
   logic [FRAME_W-1:0] stamp_mem [CACHE_ENTRIES];
   logic [KEY_W-1:0]   rd_key_ff;
   logic [FRAME_W-1:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         key_mem[mem_wr.addr]   <= mem_wr.key;
         stamp_mem[mem_wr.addr] <= mem_wr.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule
